// ===== rtl/core/ffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types, widths and codes of the first-fit byte allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int MEM_BYTES = 256;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int POS_W     = ((ADDR_W > 8) ? ADDR_W : 8) + 1;
  localparam int SIZE_W    = 9;
  localparam int BADDR_W   = 9;
  localparam int HDR_W     = 8;
  localparam int GRANT_W   = 8;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [HDR_W-1:0]   hdr_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [BADDR_W-1:0] baddr_t;
  typedef logic [GRANT_W-1:0] grant_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOCATED    = 2'd0,
    ST_ALLOC_FAIL   = 2'd1,
    ST_FREED        = 2'd2,
    ST_FREE_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    rd_k;
    logic    pos_skip;
    logic    pos_jump;
    logic    k_init_alloc;
    logic    k_init_free;
    logic    k_inc;
    logic    wr_head;
    logic    wr_clr;
    logic    fire;
    status_t fire_status;
  } ffa_cmd_t;

  typedef struct packed {
    logic op_free;
    logic size_bad;
    logic pos_end;
    logic rd_zero;
    logic run_oob;
    logic k_last;
  } ffa_stat_t;

endpackage

// ===== rtl/core/ffa_arena.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_arena
// byte arena, one write and one registered read port, per-entry valid bits
// ----------------------------------------------------------------------------
module ffa_arena (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  ffa_pkg::addr_t rd_addr,
  output ffa_pkg::hdr_t  rd_data,
  input  logic          wr_en,
  input  ffa_pkg::addr_t wr_addr,
  input  ffa_pkg::hdr_t  wr_data
);
  import ffa_pkg::*;

  hdr_t                 arena_r [MEM_BYTES];
  logic [MEM_BYTES-1:0] valid_r;
  hdr_t                 rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      arena_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= arena_r[rd_addr];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== rtl/core/ffa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_dp
// allocator datapath: scan pointers, arena access and result register
// ----------------------------------------------------------------------------
module ffa_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::ffa_cmd_t  cmd,
  output ffa_pkg::ffa_stat_t stat,
  input  logic              in_operation,
  input  ffa_pkg::size_t     in_request_size,
  input  ffa_pkg::baddr_t    in_block_address,
  output logic              out_valid,
  output ffa_pkg::status_t   out_status,
  output ffa_pkg::grant_t    out_granted_address
);
  import ffa_pkg::*;

  logic    op_r;
  size_t   size_r;
  pos_t    pos_r, pos_nxt;
  addr_t   k_r, k_nxt;
  addr_t   end_r, end_nxt;
  logic    out_valid_r;
  status_t out_status_r;
  grant_t  out_grant_r, out_grant_nxt;

  hdr_t    rd_data;
  addr_t   rd_addr;
  addr_t   wr_addr;
  hdr_t    wr_data;

  logic [POS_W:0] run_sum;
  logic [POS_W:0] clr_sum;

  ffa_arena u_arena (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (cmd.wr_head | cmd.wr_clr),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign rd_addr = cmd.rd_k ? k_r : pos_r[ADDR_W-1:0];
  assign wr_addr = cmd.wr_head ? pos_r[ADDR_W-1:0] : k_r;
  assign wr_data = cmd.wr_head ? size_r[HDR_W-1:0] : '0;

  assign run_sum = (POS_W+1)'(pos_r) + (POS_W+1)'(size_r[HDR_W-1:0]);
  assign clr_sum = (POS_W+1)'(pos_r) + (POS_W+1)'(rd_data);

  assign stat.op_free  = op_r;
  assign stat.size_bad = (size_r == '0) || size_r[SIZE_W-1];
  assign stat.pos_end  = pos_r >= pos_t'(MEM_BYTES);
  assign stat.rd_zero  = rd_data == '0;
  assign stat.run_oob  = run_sum >= (POS_W+1)'(MEM_BYTES);
  assign stat.k_last   = k_r == end_r;

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load) begin
      pos_nxt = (in_operation == OP_FREE) ? pos_t'(in_block_address) - 1'b1 : '0;
    end else if (cmd.pos_skip) begin
      pos_nxt = pos_r + pos_t'(rd_data) + 1'b1;
    end else if (cmd.pos_jump) begin
      pos_nxt = pos_t'(k_r);
    end
  end

  always_comb begin
    k_nxt   = k_r;
    end_nxt = end_r;
    if (cmd.k_init_alloc) begin
      k_nxt   = pos_r[ADDR_W-1:0] + 1'b1;
      end_nxt = run_sum[ADDR_W-1:0];
    end else if (cmd.k_init_free) begin
      k_nxt   = pos_r[ADDR_W-1:0];
      end_nxt = (clr_sum >= (POS_W+1)'(MEM_BYTES)) ? addr_t'(MEM_BYTES - 1)
                                                    : clr_sum[ADDR_W-1:0];
    end else if (cmd.k_inc) begin
      k_nxt = k_r + 1'b1;
    end
  end

  always_comb begin
    out_grant_nxt = '0;
    if (cmd.fire_status == ST_ALLOCATED) begin
      out_grant_nxt = GRANT_W'(pos_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      size_r <= in_request_size;
    end
    pos_r <= pos_nxt;
    k_r   <= k_nxt;
    end_r <= end_nxt;
    if (cmd.fire) begin
      out_status_r <= cmd.fire_status;
      out_grant_r  <= out_grant_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fire;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_grant_r;

`ifndef SYNTHESIS
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_ALLOCATED) |-> out_grant_r == '0)
    else $error("granted address nonzero on a non-allocating result");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_head && cmd.wr_clr))
    else $error("header write and clear in the same cycle");

  a_head_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_head |-> (!stat.pos_end && !stat.run_oob && stat.rd_zero))
    else $error("header written outside a free run");
`endif

endmodule

// ===== rtl/core/ffa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl
// allocator sequencer: first-fit scan and block clearing
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffa_pkg::ffa_stat_t  stat,
  output ffa_pkg::ffa_cmd_t   cmd
);
  import ffa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_A_RD,
    S_A_HD,
    S_R_RD,
    S_R_CHK,
    S_F_RD,
    S_F_HD,
    S_F_CLR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.fire_status = ST_ALLOC_FAIL;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op_free == OP_FREE) begin
          if (stat.pos_end) begin
            cmd.fire        = 1'b1;
            cmd.fire_status = ST_FREE_IGNORED;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_F_RD;
          end
        end else if (stat.size_bad) begin
          cmd.fire  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin
        if (stat.pos_end) begin
          cmd.fire  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_A_HD;
        end
      end
      S_A_HD: begin
        if (!stat.rd_zero) begin
          cmd.pos_skip = 1'b1;
          state_nxt    = S_A_RD;
        end else if (stat.run_oob) begin
          // no later start can fit either
          cmd.fire  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.k_init_alloc = 1'b1;
          state_nxt        = S_R_RD;
        end
      end
      S_R_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_k  = 1'b1;
        state_nxt = S_R_CHK;
      end
      S_R_CHK: begin
        if (!stat.rd_zero) begin
          // every start up to here overlaps this header
          cmd.pos_jump = 1'b1;
          state_nxt    = S_A_RD;
        end else if (stat.k_last) begin
          cmd.wr_head     = 1'b1;
          cmd.fire        = 1'b1;
          cmd.fire_status = ST_ALLOCATED;
          state_nxt       = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_R_RD;
        end
      end
      S_F_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_F_HD;
      end
      S_F_HD: begin
        if (stat.rd_zero) begin
          cmd.fire        = 1'b1;
          cmd.fire_status = ST_FREE_IGNORED;
          state_nxt       = S_IDLE;
        end else begin
          cmd.k_init_free = 1'b1;
          state_nxt       = S_F_CLR;
        end
      end
      S_F_CLR: begin
        cmd.wr_clr = 1'b1;
        if (stat.k_last) begin
          cmd.fire        = 1'b1;
          cmd.fire_status = ST_FREED;
          state_nxt       = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |=> !busy)
    else $error("result issued without returning to idle");

  a_no_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !(cmd.fire || cmd.rd_en || cmd.wr_head || cmd.wr_clr))
    else $error("datapath command while idle");
`endif

endmodule

// ===== rtl/core/first_fit_byte_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_byte_allocator
// first-fit allocator over a 256-byte arena of size-headed blocks
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low: in_operation
// selects allocate or free, in_request_size gives the data bytes wanted, and
// in_block_address the data address of a block to free. Exactly one result
// follows, shown for one cycle with out_valid high, carrying out_status and
// out_granted_address; the receiver cannot stall it and must take it then.
// Allocation walks the arena from address 0 through the single read port,
// reading each header it visits and each byte of a candidate run it checks; a
// bad size fails without reading the arena. A free clears the block's header
// and data bytes (size + 1). busy stays high from acceptance until the result
// is shown; the next request can be taken in the cycle the result is on the
// ports.
// Synchronous reset clears the sequencer and the per-byte valid bits at once,
// so the arena reads as all zero right after reset.
// ----------------------------------------------------------------------------
module first_fit_byte_allocator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_operation,
  input  ffa_pkg::size_t   in_request_size,
  input  ffa_pkg::baddr_t  in_block_address,
  output logic            out_valid,
  output ffa_pkg::status_t out_status,
  output ffa_pkg::grant_t  out_granted_address
);
  import ffa_pkg::*;

  ffa_cmd_t  cmd;
  ffa_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ffa_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_operation),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_address (out_granted_address)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first-fit byte allocator
// ----------------------------------------------------------------------------
// Drives allocate and free requests through the start/busy handshake. A
// scoreboard keeps its own copy of the arena, predicts the status and granted
// address of every accepted request and compares each strobed reply in order.
// A directed opening covers bad sizes, a full arena, runs that would pass the
// arena end and frees of null, stray and far addresses. Random traffic with
// varying sender gaps follows: allocations, mostly of small sizes, and frees,
// mostly of live blocks, in about equal shares.
// ----------------------------------------------------------------------------
module tb;
  import ffa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    status_t status;
    grant_t  grant;
  } reply_t;

  class arena_scoreboard;
    hdr_t        arena_bytes [MEM_BYTES];
    reply_t      pending_replies [$];
    int unsigned mismatches;

    function new();
      foreach (arena_bytes[i]) arena_bytes[i] = '0;
      mismatches = 0;
    endfunction

    function reply_t note_request(logic op, size_t sz, baddr_t ba);
      reply_t      r;
      int unsigned pos;
      int unsigned head;
      int unsigned len;
      int unsigned k;
      bit          fits;
      r.grant = '0;
      if (op == OP_ALLOC) begin
        r.status = ST_ALLOC_FAIL;
        pos = 0;
        while (r.status == ST_ALLOC_FAIL && sz != 0 && sz <= 255 && pos < MEM_BYTES) begin
          if (arena_bytes[pos] != '0) begin
            pos = pos + 32'(arena_bytes[pos]) + 1;
          end else begin
            fits = (pos + 32'(sz) < MEM_BYTES);
            for (k = pos; fits && k <= pos + 32'(sz); k++) begin
              if (arena_bytes[k] != '0) fits = 1'b0;
            end
            if (fits) begin
              arena_bytes[pos] = hdr_t'(sz);
              r.status = ST_ALLOCATED;
              r.grant = grant_t'(pos + 1);
            end else begin
              pos = pos + 1;
            end
          end
        end
      end else begin
        r.status = ST_FREE_IGNORED;
        if (ba != 0) begin
          head = 32'(ba) - 1;
          if (head < MEM_BYTES) begin
            if (arena_bytes[head] != '0) begin
              len = 32'(arena_bytes[head]);
              for (k = head; k <= head + len && k < MEM_BYTES; k++) arena_bytes[k] = '0;
              r.status = ST_FREED;
            end
          end
        end
      end
      pending_replies.push_back(r);
      return r;
    endfunction

    function void check_reply(status_t st, grant_t g);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: status %0d granted %0d", st, g);
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status || g !== want.grant) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: expected status %0d granted %0d, got status %0d granted %0d",
                   want.status, want.grant, st, g);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  logic    in_operation;
  size_t   in_request_size;
  baddr_t  in_block_address;
  logic    out_valid;
  status_t out_status;
  grant_t  out_granted_address;

  arena_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     cycle_count = 0;
  int unsigned     live_addrs [$];

  first_fit_byte_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_address (out_granted_address)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_reply(out_status, out_granted_address);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("first_fit_byte_allocator test failed");
      $finish;
    end
  end

  // one request through the handshake, with live block bookkeeping
  task automatic drive_request(input logic op, input size_t sz, input baddr_t ba,
                               output reply_t rep);
    int unsigned i;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      in_operation = 1'($urandom);
      in_request_size = size_t'($urandom);
      in_block_address = baddr_t'($urandom);
    end
    @(negedge clk);
    start = 1'b1;
    in_operation = op;
    in_request_size = sz;
    in_block_address = ba;
    @(posedge clk);
    while (busy) @(posedge clk);
    rep = sb.note_request(op, sz, ba);
    if (rep.status == ST_ALLOCATED) begin
      live_addrs.push_back(32'(rep.grant));
    end else if (rep.status == ST_FREED) begin
      for (i = 0; i < live_addrs.size(); i++) begin
        if (live_addrs[i] == 32'(ba)) begin
          live_addrs.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned served;
    int unsigned r;
    int unsigned idx;
    logic        op;
    size_t       sz;
    baddr_t      ba;
    reply_t      rep;
    served = 0;
    while (served < target) begin
      r = $urandom_range(0, 99);
      sz = size_t'($urandom);
      ba = baddr_t'($urandom_range(0, 256));
      if (r < 48) begin
        op = OP_ALLOC;
        r = $urandom_range(0, 99);
        if (r < 70) sz = size_t'($urandom_range(1, 16));
        else if (r < 90) sz = size_t'($urandom_range(17, 80));
        else if (r < 97) sz = size_t'($urandom_range(81, 255));
        else if (r < 98) sz = '0;
        else sz = size_t'($urandom_range(256, 511));
      end else begin
        op = OP_FREE;
        if (live_addrs.size() != 0) begin
          idx = $urandom_range(0, live_addrs.size() - 1);
          // stray frees land just inside or just past a live block
          if (r < 88) ba = baddr_t'(live_addrs[idx]);
          else if (r < 94) ba = baddr_t'(live_addrs[idx] + $urandom_range(1, 3));
        end
      end
      drive_request(op, sz, ba, rep);
      served++;
    end
  endtask

  initial begin
    reply_t rep;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_ALLOC;
    in_request_size = '0;
    in_block_address = '0;
    idle_pct = 20;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // bad sizes, then one block filling the arena and a request that finds it full
    drive_request(OP_ALLOC, 9'd0, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd256, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd511, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd255, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd1, baddr_t'($urandom), rep);
    // null, stray and far frees, then the full block freed twice
    drive_request(OP_FREE, size_t'($urandom), 9'd0, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd2, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd256, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd300, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd511, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd1, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd1, rep);
    // small blocks, a hole and its reuse
    drive_request(OP_ALLOC, 9'd1, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd1, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd7, baddr_t'($urandom), rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd3, rep);
    drive_request(OP_ALLOC, 9'd2, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd1, baddr_t'($urandom), rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd1, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd3, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd5, rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd13, rep);
    // last free byte cannot take a header and one data byte
    drive_request(OP_ALLOC, 9'd254, baddr_t'($urandom), rep);
    drive_request(OP_ALLOC, 9'd1, baddr_t'($urandom), rep);
    drive_request(OP_FREE, size_t'($urandom), 9'd1, rep);

    run_random(250);
    idle_pct = 59;
    run_random(250);
    idle_pct = 0;
    run_random(250);

    @(negedge clk);
    start = 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (520) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("first_fit_byte_allocator test passed");
    end else begin
      $display("first_fit_byte_allocator test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ffa_pkg.sv
rtl/core/ffa_arena.sv
rtl/core/ffa_dp.sv
rtl/core/ffa_ctrl.sv
rtl/core/first_fit_byte_allocator.sv
verif/tb.sv
